// ===== rtl/core/caf_pkg.sv =====
`default_nettype none

package caf_pkg;

	// widths fixed by the interface
	localparam int ACCEL_W    = 17;
	localparam int GYRO_W     = 20;
	localparam int COEF_W     = 17;
	localparam int OUT_W      = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;
	localparam int ADDR_W     = 4;

	localparam int FRAC_BITS_DEF = 16;

	localparam int COEF_ONE     = 65536;
	localparam int OUT_SCALE    = 100;
	localparam int WEIGHT_RST   = 1311;
	localparam int GAIN_RST     = 58982;
	localparam int PERIOD_RST   = 655;

	typedef enum logic [1:0] {
		REG_WEIGHT = 2'd0,
		REG_GAIN   = 2'd1,
		REG_PERIOD = 2'd2
	} reg_idx_t;

	// multiplier operand A
	typedef enum logic [3:0] {
		A_NONE,
		A_GYRO,
		A_GAIN,
		A_ACCEL,
		A_X,
		A_ERR,
		A_T,
		A_ONE,
		A_TWO
	} asel_t;

	// multiplier operand B, always an unsigned coefficient
	typedef enum logic [2:0] {
		B_DT,
		B_GAIN,
		B_WEIGHT,
		B_COMPL,
		B_GSQ,
		B_HUNDRED
	} bsel_t;

	// writeback action on the registered product
	typedef enum logic [3:0] {
		OP_NOP,
		OP_PRED,
		OP_GSQ,
		OP_ACC,
		OP_FIRST,
		OP_TERM,
		OP_DAMP,
		OP_INTEG,
		OP_DRIVE,
		OP_SECOND,
		OP_OUT1,
		OP_OUT2
	} op_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_WAIT_IN,
		J_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		asel_t asel;
		bsel_t bsel;
		op_t   op;
		jmp_t  jmp;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} seq_stat_t;

	typedef struct packed {
		logic take;
		logic finish;
	} seq_ev_t;

	localparam int NUM_STEPS = 14;
	localparam int STEP_W    = $clog2(NUM_STEPS);

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t FIRST_STEP = STEP_W'(1);

	// microprogram: at most one multiply issued and at most one writeback per step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		unique case (step)
			4'd0:    w = '{A_NONE,  B_DT,      OP_NOP,    J_WAIT_IN};
			4'd1:    w = '{A_GYRO,  B_DT,      OP_NOP,    J_NEXT};
			4'd2:    w = '{A_GAIN,  B_GAIN,    OP_PRED,   J_NEXT};
			4'd3:    w = '{A_ACCEL, B_WEIGHT,  OP_GSQ,    J_NEXT};
			4'd4:    w = '{A_X,     B_COMPL,   OP_ACC,    J_NEXT};
			4'd5:    w = '{A_ERR,   B_GSQ,     OP_FIRST,  J_NEXT};
			4'd6:    w = '{A_ERR,   B_GAIN,    OP_TERM,   J_NEXT};
			4'd7:    w = '{A_T,     B_DT,      OP_DAMP,   J_NEXT};
			4'd8:    w = '{A_NONE,  B_DT,      OP_INTEG,  J_NEXT};
			4'd9:    w = '{A_ONE,   B_HUNDRED, OP_DRIVE,  J_NEXT};
			4'd10:   w = '{A_X,     B_DT,      OP_OUT1,   J_NEXT};
			4'd11:   w = '{A_NONE,  B_DT,      OP_SECOND, J_NEXT};
			4'd12:   w = '{A_TWO,   B_HUNDRED, OP_NOP,    J_NEXT};
			4'd13:   w = '{A_NONE,  B_DT,      OP_OUT2,   J_WAIT_OUT};
			default: w = '{A_NONE,  B_DT,      OP_NOP,    J_WAIT_OUT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/complementary_angle_filter_core.sv =====
`default_nettype none

// Channel   Dir  Width  Contents
// s_*       in   40     tdata: accel_angle[16:0], gyro_rate[36:17], zero fill
// m_*       out  32     tdata: first_order_angle[15:0], second_order_angle[31:16]
// apb       in   4/32   weight @0x0, gain @0x4, period @0x8 (17 bit, clamped to 65536)
//
// Each item runs through one wait step plus 13 microcode steps, most steps
// issuing one product on the single 18-bit-by-AW multiplier.
// s_tready is high only in the wait step; the item is taken there.
// The result goes to an output register; the next item is taken while it waits.
// If the previous result is still held at the last step, the sequencer stalls there.
// Reset clears the three filter states, the coefficients to their defaults,
// the step counter and m_tvalid.
module complementary_angle_filter_core #(
	parameter int FRAC_BITS = caf_pkg::FRAC_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// accel_angle [16:0], gyro_rate [36:17]
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [caf_pkg::IN_DATA_W-1:0]     s_tdata,
	// first_order_angle [15:0], second_order_angle [31:16]
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [caf_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [caf_pkg::ADDR_W-1:0]        paddr,
	input  wire  [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	// input scale into the state unit
	localparam int SH = FRAC_BITS - 8;
	// error width
	localparam int EW = ((caf_pkg::ACCEL_W + SH) > 32 ? (caf_pkg::ACCEL_W + SH) : 32) + 1;
	// multiplier A width, covers predicted angle and drive term
	localparam int AW = ((21 + SH) > 32 ? (21 + SH) : 32) + 5;
	localparam int PW = AW + 18;
	localparam int SW = PW + 1;
	localparam int CW = caf_pkg::COEF_W;

	localparam logic [CW-1:0] ONE_C = CW'(caf_pkg::COEF_ONE);
	localparam logic [PW-1:0] ROUND_UP = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	// ---------------- configuration ----------------
	logic [CW-1:0] weight_q, gain_q, period_q;
	logic [CW-1:0] wr_val;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_val = (pwdata[CW-1:0] > ONE_C) ? ONE_C : pwdata[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= CW'(caf_pkg::WEIGHT_RST);
			gain_q   <= CW'(caf_pkg::GAIN_RST);
			period_q <= CW'(caf_pkg::PERIOD_RST);
		end else if (wr_en) begin
			unique case (caf_pkg::reg_idx_t'(paddr[3:2]))
				caf_pkg::REG_WEIGHT: weight_q <= wr_val;
				caf_pkg::REG_GAIN:   gain_q   <= wr_val;
				caf_pkg::REG_PERIOD: period_q <= wr_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (caf_pkg::reg_idx_t'(paddr[3:2]))
			caf_pkg::REG_WEIGHT: prdata = 32'(weight_q);
			caf_pkg::REG_GAIN:   prdata = 32'(gain_q);
			caf_pkg::REG_PERIOD: prdata = 32'(period_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	caf_pkg::ctrl_t     ctl;
	caf_pkg::seq_stat_t stat;
	caf_pkg::seq_ev_t   ev;
	logic               m_tvalid_q;
	logic               fire;

	assign stat.in_valid = s_tvalid;
	assign stat.out_free = !m_tvalid_q || m_tready;

	caf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.ev     (ev)
	);

	assign s_tready = ev.take;
	assign fire     = s_tvalid & ev.take;

	// ---------------- datapath ----------------
	logic signed [caf_pkg::ACCEL_W-1:0] ain_q;
	logic signed [caf_pkg::GYRO_W-1:0]  gin_q;
	logic signed [EW-1:0]               e_q;
	logic signed [AW-1:0]               x_q, y_q, t_q;
	logic signed [PW-1:0]               acc_q, p_q;
	logic        [CW-1:0]               k2sq_q;
	logic signed [31:0]                 a1_q, a2_q, integ_q;
	logic signed [caf_pkg::OUT_W-1:0]   first_q;
	logic [caf_pkg::OUT_DATA_W-1:0]     m_tdata_q;

	logic signed [AW-1:0] a_op;
	logic        [CW-1:0] b_op;
	logic signed [PW-1:0] prod;
	logic signed [SW-1:0] p_sw;

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic [SW-32:0] hi;
		hi = v[SW-1:31];
		if (&hi || ~|hi) begin
			return v[31:0];
		end
		return v[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	// degrees times 100, truncated toward zero, saturated
	function automatic logic signed [15:0] to_out(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] adj;
		logic signed [PW-1:0] q;
		logic [PW-16:0]       hi;
		adj = v[PW-1] ? v + $signed(ROUND_UP) : v;
		q   = adj >>> FRAC_BITS;
		hi  = q[PW-1:15];
		if (&hi || ~|hi) begin
			return q[15:0];
		end
		return q[PW-1] ? 16'sh8000 : 16'sh7fff;
	endfunction

	always_comb begin
		unique case (ctl.asel)
			caf_pkg::A_GYRO:  a_op = AW'(gin_q);
			caf_pkg::A_GAIN:  a_op = AW'($signed({1'b0, gain_q}));
			caf_pkg::A_ACCEL: a_op = AW'(ain_q);
			caf_pkg::A_X:     a_op = x_q;
			caf_pkg::A_ERR:   a_op = AW'(e_q);
			caf_pkg::A_T:     a_op = t_q;
			caf_pkg::A_ONE:   a_op = AW'(a1_q);
			caf_pkg::A_TWO:   a_op = AW'(a2_q);
			default:          a_op = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.bsel)
			caf_pkg::B_DT:      b_op = period_q;
			caf_pkg::B_GAIN:    b_op = gain_q;
			caf_pkg::B_WEIGHT:  b_op = weight_q;
			caf_pkg::B_COMPL:   b_op = ONE_C - weight_q;
			caf_pkg::B_GSQ:     b_op = k2sq_q;
			caf_pkg::B_HUNDRED: b_op = CW'(caf_pkg::OUT_SCALE);
			default:            b_op = '0;
		endcase
	end

	assign prod = a_op * $signed({1'b0, b_op});
	assign p_sw = SW'(p_q);

	// product register; held while no multiply is issued
	always_ff @(posedge clk) begin
		if (ctl.asel != caf_pkg::A_NONE) begin
			p_q <= prod;
		end
	end

	// item capture and scratch registers
	always_ff @(posedge clk) begin
		if (fire) begin
			ain_q <= s_tdata[caf_pkg::ACCEL_W-1:0];
			gin_q <= s_tdata[caf_pkg::ACCEL_W +: caf_pkg::GYRO_W];
			e_q   <= (EW'($signed(s_tdata[caf_pkg::ACCEL_W-1:0])) <<< SH) - EW'(a2_q);
		end
		unique case (ctl.op)
			// p = angle_one + floor(g*dt)
			caf_pkg::OP_PRED:  x_q    <= AW'(SW'(a1_q) + (p_sw >>> (16 - SH)));
			caf_pkg::OP_GSQ:   k2sq_q <= p_q[32:16];
			caf_pkg::OP_ACC:   acc_q  <= p_q <<< SH;
			caf_pkg::OP_TERM:  t_q    <= AW'(p_sw >>> 16);
			// floor(2*k2*e) + g
			caf_pkg::OP_DAMP:  y_q    <= AW'((p_sw >>> 15) + (SW'(gin_q) <<< SH));
			caf_pkg::OP_DRIVE: x_q    <= AW'(SW'(integ_q) + SW'(y_q));
			caf_pkg::OP_OUT1:  first_q <= to_out(p_q);
			default: ;
		endcase
		if (ev.finish) begin
			m_tdata_q <= {to_out(p_q), first_q};
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q    <= '0;
			a2_q    <= '0;
			integ_q <= '0;
		end else begin
			unique case (ctl.op)
				caf_pkg::OP_FIRST:  a1_q    <= sat32((SW'(acc_q) + p_sw) >>> 16);
				caf_pkg::OP_INTEG:  integ_q <= sat32(SW'(integ_q) + (p_sw >>> 16));
				caf_pkg::OP_SECOND: a2_q    <= sat32(SW'(a2_q) + (p_sw >>> 16));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ev.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------- checks ----------------
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_load_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctl.jmp == caf_pkg::J_WAIT_OUT))
		else $error("result loaded outside the last step");

	a_coef_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		weight_q <= ONE_C && gain_q <= ONE_C && period_q <= ONE_C)
		else $error("coefficient above one");

	a_gsq_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == caf_pkg::OP_FIRST |-> k2sq_q <= ONE_C)
		else $error("squared gain out of range");

endmodule

`default_nettype wire

// ===== rtl/core/caf_sequencer.sv =====
`default_nettype none

// step counter over the microcode table
module caf_sequencer (
	input  wire                 clk,
	input  wire                 arst_n,
	input  caf_pkg::seq_stat_t  stat,
	output caf_pkg::ctrl_t      ctl,
	output caf_pkg::seq_ev_t    ev
);

	caf_pkg::step_t step_q;
	caf_pkg::step_t step_nxt;

	assign ctl = caf_pkg::ucode(step_q);

	always_comb begin
		step_nxt  = step_q;
		ev.take   = 1'b0;
		ev.finish = 1'b0;
		unique case (ctl.jmp)
			caf_pkg::J_NEXT: begin
				step_nxt = step_q + 1'b1;
			end
			caf_pkg::J_WAIT_IN: begin
				ev.take = 1'b1;
				if (stat.in_valid) begin
					step_nxt = caf_pkg::FIRST_STEP;
				end
			end
			caf_pkg::J_WAIT_OUT: begin
				if (stat.out_free) begin
					ev.finish = 1'b1;
					step_nxt  = '0;
				end
			end
			default: begin
				step_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

`default_nettype wire
